// File: src/itse_pkg.sv
// ----------------------------------------------------------------------------
// itse_pkg
// Shared types, constants and small lookup functions for the timestamp to
// epoch nanoseconds converter.
// ----------------------------------------------------------------------------
package itse_pkg;

  localparam int unsigned YEAR_W  = 19;
  localparam int unsigned FIELD_W = 13;
  localparam int unsigned FRAC_W  = 64;
  localparam int unsigned CNT_W   = 6;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] POS_Y3   = 6'd0;
  localparam logic [CNT_W-1:0] POS_Y2   = 6'd1;
  localparam logic [CNT_W-1:0] POS_Y1   = 6'd2;
  localparam logic [CNT_W-1:0] POS_Y0   = 6'd3;
  localparam logic [CNT_W-1:0] POS_MO1  = 6'd5;
  localparam logic [CNT_W-1:0] POS_MO0  = 6'd6;
  localparam logic [CNT_W-1:0] POS_D1   = 6'd8;
  localparam logic [CNT_W-1:0] POS_D0   = 6'd9;
  localparam logic [CNT_W-1:0] POS_H1   = 6'd11;
  localparam logic [CNT_W-1:0] POS_H0   = 6'd12;
  localparam logic [CNT_W-1:0] POS_MI1  = 6'd14;
  localparam logic [CNT_W-1:0] POS_MI0  = 6'd15;
  localparam logic [CNT_W-1:0] POS_S1   = 6'd17;
  localparam logic [CNT_W-1:0] POS_S0   = 6'd18;
  localparam logic [CNT_W-1:0] POS_DOT  = 6'd19;
  localparam logic [CNT_W-1:0] POS_FRAC = 6'd20;
  localparam logic [CNT_W-1:0] CNT_MAX  = 6'd63;

  localparam logic [CNT_W-1:0] FRACTION_LIMIT = 6'd18;

  localparam logic [7:0] CHAR_DOT = 8'h2e;
  localparam logic [7:0] CHAR_Z   = 8'h5a;

  typedef struct packed {
    logic signed [YEAR_W-1:0]  year;
    logic signed [FIELD_W-1:0] month;
    logic signed [FIELD_W-1:0] day;
    logic signed [FIELD_W-1:0] hour;
    logic signed [FIELD_W-1:0] minute;
    logic signed [FIELD_W-1:0] second;
    logic [FRAC_W-1:0]         fraction;
    logic [CNT_W-1:0]          frac_cnt;
    logic                      frac_en;
  } itse_rec_t;

  // day of year at month start, months counted from march
  function automatic logic [8:0] month_doy(input logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // quotient by 100 for a year of era below 400
  function automatic logic [1:0] div100(input logic [8:0] v);
    logic [1:0] q;
    if (v >= 9'd300) begin
      q = 2'd3;
    end else if (v >= 9'd200) begin
      q = 2'd2;
    end else if (v >= 9'd100) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return q;
  endfunction

endpackage

// File: src/itse_front.sv
// ----------------------------------------------------------------------------
// itse_front
// Character parser: accumulates date, time and fraction fields by position
// and presents the finished field record on the last character.
// ----------------------------------------------------------------------------
module itse_front
  import itse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] char_code,
  input  logic       final_char,
  input  logic       accept,
  output itse_rec_t  rec
);

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_YEAR,
    TGT_MONTH,
    TGT_DAY,
    TGT_HOUR,
    TGT_MINUTE,
    TGT_SECOND
  } tgt_t;

  logic [CNT_W-1:0]          pos_r, pos_nxt;
  logic signed [YEAR_W-1:0]  year_r, year_nxt;
  logic signed [FIELD_W-1:0] month_r, month_nxt;
  logic signed [FIELD_W-1:0] day_r, day_nxt;
  logic signed [FIELD_W-1:0] hour_r, hour_nxt;
  logic signed [FIELD_W-1:0] minute_r, minute_nxt;
  logic signed [FIELD_W-1:0] second_r, second_nxt;
  logic [FRAC_W-1:0]         frac_r, frac_nxt;
  logic [CNT_W-1:0]          fcnt_r, fcnt_nxt;
  logic                      dot_r, dot_nxt;

  logic signed [8:0]  digit;
  logic [9:0]         weight;
  tgt_t               tgt;
  logic signed [19:0] term_full;
  logic signed [18:0] term;
  logic               frac_take;

  assign digit     = $signed({1'b0, char_code}) - 9'sd48;
  assign term_full = digit * $signed({1'b0, weight});
  assign term      = term_full[18:0];

  always_comb begin
    tgt    = TGT_NONE;
    weight = 10'd0;
    unique case (pos_r)
      POS_Y3:  begin tgt = TGT_YEAR;   weight = 10'd1000; end
      POS_Y2:  begin tgt = TGT_YEAR;   weight = 10'd100;  end
      POS_Y1:  begin tgt = TGT_YEAR;   weight = 10'd10;   end
      POS_Y0:  begin tgt = TGT_YEAR;   weight = 10'd1;    end
      POS_MO1: begin tgt = TGT_MONTH;  weight = 10'd10;   end
      POS_MO0: begin tgt = TGT_MONTH;  weight = 10'd1;    end
      POS_D1:  begin tgt = TGT_DAY;    weight = 10'd10;   end
      POS_D0:  begin tgt = TGT_DAY;    weight = 10'd1;    end
      POS_H1:  begin tgt = TGT_HOUR;   weight = 10'd10;   end
      POS_H0:  begin tgt = TGT_HOUR;   weight = 10'd1;    end
      POS_MI1: begin tgt = TGT_MINUTE; weight = 10'd10;   end
      POS_MI0: begin tgt = TGT_MINUTE; weight = 10'd1;    end
      POS_S1:  begin tgt = TGT_SECOND; weight = 10'd10;   end
      POS_S0:  begin tgt = TGT_SECOND; weight = 10'd1;    end
      default: begin tgt = TGT_NONE;   weight = 10'd0;    end
    endcase
  end

  always_comb begin
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    unique case (tgt)
      TGT_YEAR:   year_nxt   = year_r + term;
      TGT_MONTH:  month_nxt  = month_r + term[FIELD_W-1:0];
      TGT_DAY:    day_nxt    = day_r + term[FIELD_W-1:0];
      TGT_HOUR:   hour_nxt   = hour_r + term[FIELD_W-1:0];
      TGT_MINUTE: minute_nxt = minute_r + term[FIELD_W-1:0];
      TGT_SECOND: second_nxt = second_r + term[FIELD_W-1:0];
      default:    year_nxt   = year_r;
    endcase

    dot_nxt = dot_r;
    if (pos_r == POS_DOT) begin
      dot_nxt = (char_code == CHAR_DOT);
    end

    frac_take = (pos_r >= POS_FRAC) && dot_r && !(final_char && (char_code == CHAR_Z));
    frac_nxt  = frac_r;
    fcnt_nxt  = fcnt_r;
    if (frac_take) begin
      frac_nxt = (frac_r << 3) + (frac_r << 1) + FRAC_W'(digit);
      if (fcnt_r != CNT_MAX) begin
        fcnt_nxt = fcnt_r + 6'd1;
      end
    end

    pos_nxt = (pos_r == CNT_MAX) ? pos_r : pos_r + 6'd1;
  end

  always_comb begin
    rec.year     = year_nxt;
    rec.month    = month_nxt;
    rec.day      = day_nxt;
    rec.hour     = hour_nxt;
    rec.minute   = minute_nxt;
    rec.second   = second_nxt;
    rec.fraction = frac_nxt;
    rec.frac_cnt = fcnt_nxt;
    rec.frac_en  = (pos_r >= POS_FRAC) && dot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && final_char)) begin
      pos_r    <= '0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      frac_r   <= '0;
      fcnt_r   <= '0;
      dot_r    <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      frac_r   <= frac_nxt;
      fcnt_r   <= fcnt_nxt;
      dot_r    <= dot_nxt;
    end
  end

endmodule

// File: src/itse_fifo.sv
// ----------------------------------------------------------------------------
// itse_fifo
// Short record queue between the character parser and the converter.
// ----------------------------------------------------------------------------
module itse_fifo
  import itse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  itse_rec_t wr_rec,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output itse_rec_t rd_rec
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(QUEUE_DEPTH);

  itse_rec_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

// File: src/itse_back.sv
// ----------------------------------------------------------------------------
// itse_back
// Converter: turns one field record into nanoseconds since the epoch through
// a fixed sequence of narrow multiply and add steps, then holds the word in
// an output register until it is taken.
// ----------------------------------------------------------------------------
module itse_back
  import itse_pkg::*;
#(
  parameter int unsigned NANO_DIGITS = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  itse_rec_t          q_rec,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic signed [63:0] out_epoch_ns
);

  localparam int unsigned SCALE_W = $clog2(NANO_DIGITS + 1);
  localparam logic [CNT_W-1:0] NANO_CNT = CNT_W'(NANO_DIGITS);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_MON   = 13'b0000000000010,
    ST_YEAR  = 13'b0000000000100,
    ST_ERA   = 13'b0000000001000,
    ST_YOE   = 13'b0000000010000,
    ST_DOE   = 13'b0000000100000,
    ST_DAYS  = 13'b0000001000000,
    ST_SECS  = 13'b0000010000000,
    ST_MLO   = 13'b0000100000000,
    ST_MHI   = 13'b0001000000000,
    ST_SCALE = 13'b0010000000000,
    ST_SUM   = 13'b0100000000000,
    ST_OUT   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take_out, out_load;

  itse_rec_t          rec_r;
  logic [7:0]         q12_r;
  logic [3:0]         month_r;
  logic [18:0]        x400_r;
  logic signed [24:0] hms_r;
  logic [9:0]         q400_r;
  logic [8:0]         yoe_r;
  logic signed [10:0] era_r;
  logic [3:0]         mp_r;
  logic [17:0]        doe_r;
  logic signed [28:0] days_r;
  logic signed [47:0] secs_r;
  logic [53:0]        plo_r;
  logic [39:0]        phi_r;
  logic [63:0]        nanos_r;
  logic [SCALE_W-1:0] scale_r;
  logic [63:0]        acc_r;
  logic [63:0]        out_data_r;

  logic signed [12:0] x12_s;
  logic [11:0]        x12;
  logic [24:0]        p12;
  logic [11:0]        m_w;
  logic               m_low;
  logic signed [8:0]  yadj;
  logic signed [18:0] y_s;
  logic signed [18:0] yy_s;
  logic signed [18:0] x400_s;
  logic signed [24:0] hms_w;
  logic [38:0]        p400;
  logic [18:0]        yoe_w;
  logic signed [10:0] era_w;
  logic [17:0]        doe_w;
  logic signed [28:0] days_w;
  logic signed [47:0] secs_w;
  logic [53:0]        plo_w;
  logic signed [53:0] phi_w;
  logic               frac_ok;
  logic [CNT_W-1:0]   scale_diff;

  // month normalization: (month - 1) / 12 with an offset that keeps it positive
  assign x12_s  = rec_r.month + 13'sd575;
  assign x12    = x12_s[11:0];
  assign p12    = x12 * 13'd5462;
  assign m_w    = x12 - ({4'd0, q12_r} << 3) - ({4'd0, q12_r} << 2) + 12'd1;
  assign m_low  = (m_w[3:0] <= 4'd2);
  assign yadj   = $signed({1'b0, q12_r}) - 9'sd48;
  assign y_s    = rec_r.year + 19'(yadj);
  assign yy_s   = y_s - (m_low ? 19'sd1 : 19'sd0);
  assign x400_s = yy_s + 19'sd53600;
  assign hms_w  = 25'(rec_r.hour) * 25'sd3600 + 25'(rec_r.minute) * 25'sd60
                + 25'(rec_r.second);

  // era from the offset year, 400 years per era
  assign p400  = x400_r * 20'd671089;
  assign yoe_w = x400_r - 19'(q400_r) * 19'd400;
  assign era_w = $signed({1'b0, q400_r}) - 11'sd134;

  assign doe_w = 18'(yoe_r) * 18'd365 + 18'(yoe_r[8:2]) - 18'(div100(yoe_r))
               + 18'(month_doy(mp_r));
  assign days_w = era_r * 29'sd146097 + $signed({11'd0, doe_r}) + 29'(rec_r.day)
                - 29'sd719469;
  assign secs_w = days_r * 48'sd86400 + 48'(hms_r);

  // seconds times 1e9 split into two partial products
  assign plo_w = secs_r[23:0] * 30'd1000000000;
  assign phi_w = $signed(secs_r[47:24]) * 54'sd1000000000;

  assign frac_ok    = q_rec.frac_en && (q_rec.frac_cnt <= FRACTION_LIMIT);
  assign scale_diff = NANO_CNT - q_rec.frac_cnt;

  assign take_out     = out_pop && out_valid_r;
  assign out_load     = (state_r == ST_OUT) && (!out_valid_r || take_out);
  assign q_pop        = (state_r == ST_IDLE) && !q_empty;
  assign out_empty    = !out_valid_r;
  assign out_epoch_ns = $signed(out_data_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (!q_empty) state_nxt = ST_MON;
      ST_MON:   state_nxt = ST_YEAR;
      ST_YEAR:  state_nxt = ST_ERA;
      ST_ERA:   state_nxt = ST_YOE;
      ST_YOE:   state_nxt = ST_DOE;
      ST_DOE:   state_nxt = ST_DAYS;
      ST_DAYS:  state_nxt = ST_SECS;
      ST_SECS:  state_nxt = ST_MLO;
      ST_MLO:   state_nxt = ST_MHI;
      ST_MHI:   state_nxt = ST_SCALE;
      ST_SCALE: if (scale_r == '0) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r && !take_out;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          rec_r   <= q_rec;
          nanos_r <= frac_ok ? q_rec.fraction : 64'd0;
          scale_r <= (q_rec.frac_cnt < NANO_CNT) ? scale_diff[SCALE_W-1:0] : '0;
        end
      end
      ST_MON: begin
        q12_r <= p12[23:16];
      end
      ST_YEAR: begin
        month_r <= m_w[3:0];
        x400_r  <= x400_s[18:0];
        hms_r   <= hms_w;
      end
      ST_ERA: begin
        q400_r <= p400[37:28];
      end
      ST_YOE: begin
        yoe_r <= yoe_w[8:0];
        era_r <= era_w;
        mp_r  <= (month_r > 4'd2) ? month_r - 4'd3 : month_r + 4'd9;
      end
      ST_DOE: begin
        doe_r <= doe_w;
      end
      ST_DAYS: begin
        days_r <= days_w;
      end
      ST_SECS: begin
        secs_r <= secs_w;
      end
      ST_MLO: begin
        plo_r <= plo_w;
      end
      ST_MHI: begin
        phi_r <= phi_w[39:0];
      end
      ST_SCALE: begin
        if (scale_r != '0) begin
          nanos_r <= (nanos_r << 3) + (nanos_r << 1);
          scale_r <= scale_r - 1'b1;
        end
      end
      ST_SUM: begin
        acc_r <= 64'(plo_r) + {phi_r, 24'd0};
      end
      ST_OUT: begin
        if (out_load) begin
          out_data_r <= acc_r + nanos_r;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

endmodule

// File: src/iso_timestamp_to_epoch_ns.sv
// ----------------------------------------------------------------------------
// iso_timestamp_to_epoch_ns
// Converts a UTC timestamp YYYY-MM-DDThh:mm:ss[.fff...][Z], one character per
// word, into signed 64-bit nanoseconds since 1970-01-01T00:00:00Z.
// ----------------------------------------------------------------------------
// The parser takes one character every cycle and never stalls while the
// two-entry record queue has room. Each timestamp is then converted through
// the states from ST_MON to ST_OUT, with one pass of the shared multiply-by-ten
// step in ST_SCALE for each step by which the fraction digit count falls short
// of NANO_DIGITS, also when no fraction is present. Strings that are shorter
// than their conversion time and follow each other closely fill the queue and
// stall the input. The result waits in an output register; the queue lets the
// parser run ahead while it is held.
module iso_timestamp_to_epoch_ns
  import itse_pkg::*;
#(
  parameter int unsigned NANO_DIGITS = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_char_code,
  input  logic               in_final_char,
  input  logic               in_push,
  output logic               in_full,
  output logic signed [63:0] out_epoch_ns,
  output logic               out_empty,
  input  logic               out_pop
);

  itse_rec_t front_rec;
  itse_rec_t q_rec;
  logic      in_accept;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;
  assign q_push    = in_accept && in_final_char;

  itse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_code  (in_char_code),
    .final_char (in_final_char),
    .accept     (in_accept),
    .rec        (front_rec)
  );

  itse_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (front_rec),
    .pop    (q_pop),
    .full   (q_full),
    .empty  (q_empty),
    .rd_rec (q_rec)
  );

  itse_back #(
    .NANO_DIGITS (NANO_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_rec        (q_rec),
    .q_pop        (q_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_epoch_ns (out_epoch_ns)
  );

`ifndef SYNTHESIS
  a_push_not_full : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("record pushed into a full queue");

  a_pop_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("record popped from an empty queue");

  a_record_kept : assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && !q_pop) |=> !q_empty)
    else $error("queued record lost without a pop");
`endif

endmodule

// File: sim/iso_timestamp_to_epoch_ns_test.sv
// ----------------------------------------------------------------------------
// iso_timestamp_to_epoch_ns_test
// Feeds timestamp text one character per word and checks every converted
// epoch value. A directed set of strings covers date extremes, fraction
// handling, month wrap, stray characters and overlong text. Random strings
// follow: mostly well formed, some corrupted, some pure noise. The sender
// runs in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module iso_timestamp_to_epoch_ns_test;
  import itse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NANO_DIGITS = 9;
  localparam int          IDLE_LIMIT  = 5000;
  localparam int          LONG_HOLD   = 400;
  localparam int          TAIL_CYCLES = 60;

  typedef logic [7:0] text_t[$];

  typedef struct {
    logic [7:0] code;
    logic       last;
    logic       drain;
  } char_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic [7:0]         in_char_code = 8'd0;
  logic               in_final_char = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic signed [63:0] out_epoch_ns;
  logic               out_empty;
  logic               out_pop = 1'b0;

  char_word_t pending_chars[$];
  longint     epoch_expected[$];
  int         error_count = 0;
  int         results_seen = 0;

  // running copy of the parser state
  logic [CNT_W-1:0] char_pos;
  longint           year_acc, month_acc, day_acc, hour_acc, minute_acc, second_acc;
  logic [63:0]      frac_acc;
  logic [CNT_W-1:0] frac_cnt;
  logic             dot_flag;

  iso_timestamp_to_epoch_ns #(
    .NANO_DIGITS(NANO_DIGITS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char_code (in_char_code),
    .in_final_char(in_final_char),
    .in_push      (in_push),
    .in_full      (in_full),
    .out_epoch_ns (out_epoch_ns),
    .out_empty    (out_empty),
    .out_pop      (out_pop)
  );

  always #1 clk = ~clk;

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // days from 1970-01-01 to the first of month m of year y
  function automatic longint days_before_month(input longint y, input longint m);
    longint yy, era, yoe, mp, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = floor_div(yy, 400);
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic longint epoch_of_text(input logic with_frac);
    longint      m0, yadj, y, m, days, secs;
    logic [63:0] nanos;
    m0    = month_acc - 1;
    yadj  = floor_div(m0, 12);
    y     = year_acc + yadj;
    m     = m0 - yadj * 12 + 1;
    days  = days_before_month(y, m) + day_acc - 1;
    secs  = days * 86400 + hour_acc * 3600 + minute_acc * 60 + second_acc;
    nanos = 64'd0;
    if (with_frac && frac_cnt <= FRACTION_LIMIT) begin
      nanos = frac_acc;
      for (int k = frac_cnt; k < NANO_DIGITS; k++) nanos = nanos * 64'd10;
    end
    return longint'(unsigned'(secs) * 64'd1_000_000_000 + nanos);
  endfunction

  task automatic clear_text_state();
    char_pos   = '0;
    year_acc   = 0;
    month_acc  = 0;
    day_acc    = 0;
    hour_acc   = 0;
    minute_acc = 0;
    second_acc = 0;
    frac_acc   = 64'd0;
    frac_cnt   = '0;
    dot_flag   = 1'b0;
  endtask

  task automatic absorb_char(input logic [7:0] c, input logic last);
    longint           d;
    logic [CNT_W-1:0] p;
    d = longint'(c) - 48;
    p = char_pos;
    case (p)
      POS_Y3:  year_acc   += d * 1000;
      POS_Y2:  year_acc   += d * 100;
      POS_Y1:  year_acc   += d * 10;
      POS_Y0:  year_acc   += d;
      POS_MO1: month_acc  += d * 10;
      POS_MO0: month_acc  += d;
      POS_D1:  day_acc    += d * 10;
      POS_D0:  day_acc    += d;
      POS_H1:  hour_acc   += d * 10;
      POS_H0:  hour_acc   += d;
      POS_MI1: minute_acc += d * 10;
      POS_MI0: minute_acc += d;
      POS_S1:  second_acc += d * 10;
      POS_S0:  second_acc += d;
      POS_DOT: dot_flag = (c == CHAR_DOT);
      default: ;
    endcase
    if (p >= POS_FRAC && dot_flag && !(last && c == CHAR_Z)) begin
      frac_acc = frac_acc * 64'd10 + unsigned'(d);
      if (frac_cnt != CNT_MAX) frac_cnt = frac_cnt + 1'b1;
    end
    if (char_pos != CNT_MAX) char_pos = char_pos + 1'b1;
    if (last) begin
      epoch_expected.push_back(epoch_of_text(p >= POS_FRAC && dot_flag));
      clear_text_state();
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("mismatch %s: got %0d (0x%016h) expected %0d (0x%016h) at %0t",
             what, got, got, want, want, $realtime);
  endtask

  function automatic text_t text_of(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  task automatic queue_text(input text_t t);
    char_word_t w;
    for (int i = 0; i < t.size(); i++) begin
      w.code  = t[i];
      w.last  = (i == t.size() - 1);
      w.drain = 1'b0;
      pending_chars.push_back(w);
    end
  endtask

  task automatic queue_drain();
    char_word_t w;
    w.code  = 8'd0;
    w.last  = 1'b0;
    w.drain = 1'b1;
    pending_chars.push_back(w);
  endtask

  function automatic int pick_field(input int lo, input int hi);
    return ($urandom_range(9) == 0) ? int'($urandom_range(99)) : int'($urandom_range(hi, lo));
  endfunction

  function automatic text_t random_timestamp();
    string s;
    int    n_frac;
    s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", $urandom_range(9999),
                  pick_field(1, 12), pick_field(1, 31), pick_field(0, 23),
                  pick_field(0, 59), pick_field(0, 59));
    if ($urandom_range(3) != 0) begin
      s = {s, "."};
      case ($urandom_range(9))
        0:       n_frac = $urandom_range(45, 19);
        1:       n_frac = $urandom_range(18, 10);
        default: n_frac = $urandom_range(9);
      endcase
      for (int i = 0; i < n_frac; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
    end
    if ($urandom_range(1) == 1) s = {s, "Z"};
    return text_of(s);
  endfunction

  function automatic text_t random_noise();
    text_t t;
    int    n;
    n = ($urandom_range(4) == 0) ? $urandom_range(70, 20) : $urandom_range(19, 1);
    for (int i = 0; i < n; i++) t.push_back(8'($urandom_range(255)));
    return t;
  endfunction

  // sender: bursts of words with random gaps, pauses at drain markers
  always @(posedge clk) begin : drive_chars
    logic       push_next;
    logic [7:0] code_next;
    logic       last_next;
    int         burst_left;
    int         gap_left;
    push_next = in_push;
    code_next = in_char_code;
    last_next = in_final_char;
    if (rst_n) begin
      if (in_push && !in_full) begin
        absorb_char(in_char_code, in_final_char);
        void'(pending_chars.pop_front());
        push_next = 1'b0;
      end
      if (!push_next) begin
        if (pending_chars.size() > 0 && pending_chars[0].drain) begin
          if (epoch_expected.size() == 0) void'(pending_chars.pop_front());
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (pending_chars.size() > 0) begin
          push_next = 1'b1;
          code_next = pending_chars[0].code;
          last_next = pending_chars[0].last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(200, 60) :
                                                    $urandom_range(30, 1);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
          end
        end
      end
    end
    in_push       <= push_next;
    in_char_code  <= code_next;
    in_final_char <= last_next;
  end

  // receiver: checks each popped word, stalls on its own pattern
  always @(posedge clk) begin : collect_epochs
    logic pop_next;
    int   run_left;
    int   hold_left;
    bit   hold_done;
    longint want;
    pop_next = out_pop;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (epoch_expected.size() == 0) begin
          report_mismatch("unexpected epoch_ns", out_epoch_ns, 0);
        end else begin
          want = epoch_expected.pop_front();
          if (out_epoch_ns !== want) report_mismatch("epoch_ns", out_epoch_ns, want);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else if (!hold_done && results_seen >= 20) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        pop_next  = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        pop_next = ~out_pop;
        run_left = pop_next ? $urandom_range(40, 1) : $urandom_range(10);
      end
    end
    out_pop <= pop_next;
  end

  // ends the run when neither side moves for too long
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles = 0;
    end else if (rst_n) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL iso_timestamp_to_epoch_ns");
        $finish;
      end
    end
  end

  initial begin
    text_t t;
    int    n_items;
    int    n_strings;
    int    idx;
    clear_text_state();

    // epoch origin, leap day with full and partial fractions
    queue_text(text_of("1970-01-01T00:00:00Z"));
    queue_text(text_of("2024-02-29T23:59:59.123456789Z"));
    queue_text(text_of("2024-02-29T23:59:59.1"));
    queue_text(text_of("2024-02-29T23:59:59.123456789012"));
    queue_text(text_of("2024-02-29T23:59:59.1234567890123456789"));
    // year extremes
    queue_text(text_of("0000-01-01T00:00:00"));
    queue_text(text_of("9999-12-31T23:59:59.999999999Z"));
    // month zero and past december
    queue_text(text_of("2000-00-15T12:00:00"));
    queue_text(text_of("1999-13-01T00:00:00Z"));
    queue_text(text_of("1999-99-99T99:99:99"));
    // short strings and a dot with no fraction after it
    queue_text(text_of("5"));
    queue_text(text_of("2021-0"));
    queue_text(text_of("2021-01-01T00:00:00."));
    queue_text(text_of("2021-01-01T00:00:00.Z"));
    // a z that is not final counts as a digit after a dot; in the dot's place it turns the fraction off
    queue_text(text_of("2021-01-01T00:00:00.Z5"));
    queue_text(text_of("2021-01-01T00:00:00Z5"));
    // stray characters and all-ones / all-zeros codes
    queue_text(text_of("abcd-ef-ghTij:kl:mn.xyz"));
    t = text_of("2021-01-01T00:00:00.5");
    t[0] = 8'hff;
    t[20] = 8'h00;
    queue_text(t);
    // text running past the position counter
    t = text_of("2021-06-15T08:30:45.");
    repeat (5) t = {t, text_of("0123456789")};
    t.push_back(CHAR_Z);
    queue_text(t);
    queue_drain();

    n_items   = pending_chars.size();
    n_strings = 0;
    while (n_items < 1000) begin
      case ($urandom_range(9))
        0: t = random_noise();
        1: begin
          t = random_timestamp();
          idx = $urandom_range(t.size() - 1);
          t[idx] = 8'($urandom_range(255));
          if ($urandom_range(1) == 1) t = t[0:$urandom_range(t.size() - 1)];
        end
        default: t = random_timestamp();
      endcase
      queue_text(t);
      n_items += t.size();
      n_strings++;
      if (n_strings % 12 == 0) queue_drain();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() > 0 || epoch_expected.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS iso_timestamp_to_epoch_ns");
    end else begin
      $display("FAIL iso_timestamp_to_epoch_ns");
    end
    $finish;
  end

endmodule
